FILE: design/tapi_pkg.sv
// Shared types, widths and helpers for the triangle point-inside unit.
package tapi_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CFG_IDX_W   = 3;
  // point_x and point_y packed side by side, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0X = 3'd0,
    REG_V0Y = 3'd1,
    REG_V1X = 3'd2,
    REG_V1Y = 3'd3,
    REG_V2X = 3'd4,
    REG_V2Y = 3'd5
  } cfg_reg_t;

  // Triangle setup handed from the config block to the datapath.
  typedef struct packed {
    coord_t [2:0] vx;
    coord_t [2:0] vy;
    diff_t  [2:0] ex;      // edge i runs from vertex i to vertex i+1
    diff_t  [2:0] ey;
    prod_t        wind_p;  // winding = wind_p - wind_q
    prod_t        wind_q;
  } tri_t;

  // Pipeline output toward the result register.
  typedef struct packed {
    logic valid;
    logic pt_in;
    logic last;
  } res_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t mul_d(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

FILE: design/tapi_cfg.sv
// Vertex registers and derived triangle setup (edges, winding products).
module tapi_cfg
  import tapi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  output tri_t                 tri_o
);

  coord_t [2:0] vx_r, vy_r;
  diff_t  [2:0] ex_r, ey_r;
  diff_t        bx_r, by_r;
  prod_t        wp_r, wq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= '0;
      vy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_V0X: vx_r[0] <= coord_t'(cfg_data);
        REG_V0Y: vy_r[0] <= coord_t'(cfg_data);
        REG_V1X: vx_r[1] <= coord_t'(cfg_data);
        REG_V1Y: vy_r[1] <= coord_t'(cfg_data);
        REG_V2X: vx_r[2] <= coord_t'(cfg_data);
        REG_V2Y: vy_r[2] <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Setup regs follow the vertices continuously: edge regs, then winding.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ex_r[i] <= sub_c(vx_r[(i+1)%3], vx_r[i]);
      ey_r[i] <= sub_c(vy_r[(i+1)%3], vy_r[i]);
    end
    bx_r <= sub_c(vx_r[2], vx_r[0]);
    by_r <= sub_c(vy_r[2], vy_r[0]);
    wp_r <= mul_d(ex_r[0], by_r);
    wq_r <= mul_d(ey_r[0], bx_r);
  end

  always_comb begin
    tri_o.vx     = vx_r;
    tri_o.vy     = vy_r;
    tri_o.ex     = ex_r;
    tri_o.ey     = ey_r;
    tri_o.wind_p = wp_r;
    tri_o.wind_q = wq_r;
  end

endmodule

FILE: design/tapi_edge.sv
// Three-stage edge-function pipeline: point capture, offsets, cross products.
module tapi_edge
  import tapi_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  coord_t px,
  input  coord_t py,
  input  logic   last,
  input  tri_t   tri_i,
  output res_t   res_o
);

  logic   v1_r, v2_r, v3_r;
  logic   l1_r, l2_r, l3_r;
  coord_t px_r, py_r;
  diff_t  [2:0] dx_r, dy_r;
  logic   vtx2_r, vtx3_r;
  prod_t  [2:0] pp_r, pq_r;

  logic   vtx_nxt;
  logic   ge_all, le_all, wind_pos, wind_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    vtx_nxt = 1'b0;
    for (int i = 0; i < 3; i++)
      if (px_r == tri_i.vx[i] && py_r == tri_i.vy[i]) vtx_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px;
      py_r   <= py;
      l1_r   <= last;
      for (int i = 0; i < 3; i++) begin
        dx_r[i] <= sub_c(px_r, tri_i.vx[i]);
        dy_r[i] <= sub_c(py_r, tri_i.vy[i]);
        pp_r[i] <= mul_d(tri_i.ex[i], dy_r[i]);
        pq_r[i] <= mul_d(tri_i.ey[i], dx_r[i]);
      end
      vtx2_r <= vtx_nxt;
      l2_r   <= l1_r;
      vtx3_r <= vtx2_r;
      l3_r   <= l2_r;
    end
  end

  always_comb begin
    ge_all = 1'b1;
    le_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (pp_r[i] < pq_r[i]) ge_all = 1'b0;
      if (pp_r[i] > pq_r[i]) le_all = 1'b0;
    end
    wind_pos     = tri_i.wind_p > tri_i.wind_q;
    wind_neg     = tri_i.wind_p < tri_i.wind_q;
    res_o.valid  = v3_r;
    res_o.last   = l3_r;
    // zero winding (degenerate) fails both arms
    res_o.pt_in  = !vtx3_r && ((wind_pos && ge_all) || (wind_neg && le_all));
  end

endmodule

FILE: design/triangle_any_point_inside_unit.sv
// Top level: stream ports, config port, result register and running flag.
//
// Accepts one test point per clock cycle while the result side keeps up;
// each point's result passes through the point, offset, cross-product and
// result registers on its way to the output. A stalled result holds the
// whole pipeline. Vertex writes pass through the vertex, edge and winding
// setup registers; they are to be made while no point is in flight.
// any_inside is the OR of point_inside over the current list and clears
// after the result carrying tlast.
module triangle_any_point_inside_unit
  import tapi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] point_x, [31:16] point_y
  input  logic                   in_tlast,   // list_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [0] point_inside, [1] any_inside
  output logic                   out_tlast,  // result_last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  tri_t tri_s;
  res_t res_s;
  logic adv;
  logic out_valid_r, inside_r, any_r, last_r, any_seen_r;
  logic any_nxt;

  tapi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tri_o     (tri_s)
  );

  tapi_edge u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .px       (coord_t'(in_tdata[COORD_WIDTH-1:0])),
    .py       (coord_t'(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .last     (in_tlast),
    .tri_i    (tri_s),
    .res_o    (res_s)
  );

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;
  assign any_nxt   = any_seen_r || res_s.pt_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      any_seen_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_s.valid;
      if (res_s.valid) any_seen_r <= res_s.last ? 1'b0 : any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= res_s.pt_in;
      any_r    <= any_nxt;
      last_r   <= res_s.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, any_r, inside_r};
  assign out_tlast  = last_r;

  a_inside_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("point_inside set without any_inside");

  a_flag_fall_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(any_seen_r) |-> $past(adv && res_s.valid && res_s.last))
    else $error("running flag cleared outside a list end");

  a_flag_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_s.valid && res_s.last) |=> !any_seen_r)
    else $error("running flag not cleared after list end");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> (!in_tready ##1 $stable(any_r)))
    else $error("result changed or input taken during stall");

endmodule
